[rtl/qph_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qph_pkg
// Shared widths, operation codes and controller/datapath command and status
// types for the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

  // payload field widths
  localparam int REQ_TYPE_W   = 2;
  localparam int KEY_FIELD_W  = 16;
  localparam int SLOT_FIELD_W = 4;

  // parameter defaults
  localparam int NUM_SLOTS_DEF = 10;
  localparam int KEY_WIDTH_DEF = 16;

  // operation codes
  localparam logic [REQ_TYPE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] OP_SEARCH = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;    // write zero at the clear pointer
    logic load;        // capture request
    logic quo_step;    // capture the home slot quotient
    logic rem_step;    // capture key minus quotient times slot count
    logic probe_init;  // start probing at the home slot
    logic probe_step;  // advance to the next quadratic probe
    logic rd;          // read table at the probe slot
    logic wr;          // update the matched slot (insert or delete)
    logic res_set;     // latch the working result
    logic res_ok;      // success value for res_set
    logic out_load;    // move working result into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;  // clear pointer at the last slot
    logic key_bad;     // zero key or unknown operation
    logic hit;         // read slot holds the wanted value
    logic probe_last;  // current probe is the last one
  } sts_t;

endpackage
`default_nettype wire

[rtl/qph_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qph_req_if / qph_rsp_if
// Valid/ready channels for requests and results of the hash table.
// ----------------------------------------------------------------------------
interface qph_req_if;
  import qph_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [KEY_FIELD_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface qph_rsp_if;
  import qph_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    success;
  logic [SLOT_FIELD_W-1:0] slot;

  modport source (output valid, output success, output slot, input ready);
  modport sink   (input valid, input success, input slot, output ready);
endinterface
`default_nettype wire

[rtl/qph_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qph_dp
// Datapath: request registers, home slot remainder by reciprocal multiply,
// quadratic probe address stepping, key memory and result registers.
// ----------------------------------------------------------------------------
module qph_dp #(
  parameter int NUM_SLOTS = qph_pkg::NUM_SLOTS_DEF,
  parameter int KEY_WIDTH = qph_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire qph_pkg::cmd_t                    cmd,
  output qph_pkg::sts_t                         sts,
  input  wire logic [qph_pkg::REQ_TYPE_W-1:0]   in_req_type,
  input  wire logic [qph_pkg::KEY_FIELD_W-1:0]  in_key,
  output logic                                  out_success,
  output logic [qph_pkg::SLOT_FIELD_W-1:0]      out_slot
);
  import qph_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int HW = (KEY_WIDTH > SW + 1) ? KEY_WIDTH : SW + 1;
  localparam logic [KEY_WIDTH-1:0] RECIP =
    KEY_WIDTH'((64'd1 << KEY_WIDTH) / 64'(NUM_SLOTS));
  localparam logic [KEY_WIDTH-1:0] TSZ_K = KEY_WIDTH'(NUM_SLOTS);
  localparam logic [HW-1:0]        TSZ_H = HW'(NUM_SLOTS);
  localparam logic [SW:0]          TSZ   = (SW + 1)'(NUM_SLOTS);

  logic [REQ_TYPE_W-1:0] op_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [KEY_WIDTH-1:0]  quo;
  logic [KEY_WIDTH-1:0]  diff;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         inc;
  logic [CW-1:0]         pcnt;
  logic [SW-1:0]         clr_addr;
  logic [KEY_WIDTH-1:0]  rdata;
  logic                  res_ok;
  logic [SW-1:0]         res_slot;

  logic [31:0]             key_ext;
  logic [KEY_WIDTH-1:0]    key_k;
  logic [2*KEY_WIDTH-1:0]  quo_prod;
  logic [KEY_WIDTH-1:0]    quo_mul;
  logic [HW-1:0]           diff_ext;
  logic [HW-1:0]           home_w;
  logic [SW-1:0]           home;
  logic [SW:0]             slot_sum;
  logic [SW-1:0]           slot_adv;
  logic [SW:0]             inc_sum;
  logic [SW-1:0]           inc_adv;
  logic [KEY_WIDTH-1:0]    want;
  logic                    wr_en;
  logic [SW-1:0]           wr_addr;
  logic [KEY_WIDTH-1:0]    wr_data;
  logic [31:0]             slot_wide;

  logic [KEY_WIDTH-1:0]  mem [NUM_SLOTS];

  // key taken modulo 2^KEY_WIDTH
  assign key_ext = 32'(in_key);
  assign key_k   = key_ext[KEY_WIDTH-1:0];

  // home slot: quotient by reciprocal multiply, low by at most one,
  // then key minus quotient times slot count and one compare and subtract
  assign quo_prod = {{KEY_WIDTH{1'b0}}, key_q} * {{KEY_WIDTH{1'b0}}, RECIP};
  assign quo_mul  = quo * TSZ_K;
  assign diff_ext = HW'(diff);
  assign home_w   = (diff_ext >= TSZ_H) ? diff_ext - TSZ_H : diff_ext;
  assign home     = home_w[SW-1:0];

  // next probe: slot += 2i+1, increment += 2, both mod table size
  assign slot_sum = {1'b0, slot} + {1'b0, inc};
  assign slot_adv = (slot_sum >= TSZ) ? SW'(slot_sum - TSZ) : slot_sum[SW-1:0];
  assign inc_sum  = {1'b0, inc} + (SW + 1)'(2);
  assign inc_adv  = (inc_sum >= TSZ) ? SW'(inc_sum - TSZ) : inc_sum[SW-1:0];

  // request and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_req_type;
      key_q <= key_k;
    end
    if (cmd.quo_step) begin
      quo <= quo_prod[2*KEY_WIDTH-1:KEY_WIDTH];
    end
    if (cmd.rem_step) begin
      diff <= key_q - quo_mul;
    end
    if (cmd.probe_init) begin
      slot <= home;
      inc  <= SW'(1);
      pcnt <= '0;
    end else if (cmd.probe_step) begin
      slot <= slot_adv;
      inc  <= inc_adv;
      pcnt <= pcnt + CW'(1);
    end
  end

  // clear pointer for the pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + SW'(1);
    end
  end

  // key memory, one write and one registered read port
  assign want    = (op_q == OP_INSERT) ? '0 : key_q;
  assign wr_en   = cmd.clear_wr || (cmd.wr && (op_q != OP_SEARCH));
  assign wr_addr = cmd.clear_wr ? clr_addr : slot;
  assign wr_data = (cmd.clear_wr || (op_q == OP_DELETE)) ? '0 : key_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata <= mem[slot];
    end
  end

  // result registers
  assign slot_wide = 32'(res_slot);

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_ok   <= cmd.res_ok;
      res_slot <= cmd.res_ok ? slot : '0;
    end
    if (cmd.out_load) begin
      out_success <= res_ok;
      out_slot    <= slot_wide[SLOT_FIELD_W-1:0];
    end
  end

  // status to the controller
  always_comb begin
    sts.clear_last = (clr_addr == SW'(NUM_SLOTS - 1));
    sts.key_bad    = (key_q == '0) ||
                     !((op_q == OP_INSERT) || (op_q == OP_DELETE) || (op_q == OP_SEARCH));
    sts.hit        = (rdata == want);
    sts.probe_last = (pcnt == CW'(NUM_SLOTS - 1));
  end

endmodule
`default_nettype wire

[rtl/qph_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qph_ctrl
// Controller: clearing pass, request sequencing through remainder, probe
// read and compare, and the output register handshake.
// ----------------------------------------------------------------------------
module qph_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qph_pkg::cmd_t      cmd,
  input  wire qph_pkg::sts_t sts
);
  import qph_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_QUO   = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_QUO;
        end
      end
      S_QUO: begin
        cmd.quo_step = 1'b1;
        state_next   = S_REM;
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        state_next   = S_START;
      end
      S_START: begin
        if (sts.key_bad) begin
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b0;
          state_next  = S_DONE;
        end else begin
          cmd.probe_init = 1'b1;
          state_next     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.wr      = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_next  = S_DONE;
        end else if (sts.probe_last) begin
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b0;
          state_next  = S_DONE;
        end else begin
          cmd.probe_step = 1'b1;
          state_next     = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/quadratic_probe_hash_table.sv]
`default_nettype none
// Sequence: an accepted request passes the quotient, remainder and setup
// states, then a read and a compare state per probe (one probe up to the
// slot count) and the result state that loads the output register; a
// rejected request goes from setup straight to the result state.
// Throughput: one request at a time. Reset: synchronous; a clearing pass
// zeroes the table slot by slot, with no request accepted until it ends.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table with quadratic probing: insert, delete, search.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
  parameter int NUM_SLOTS = qph_pkg::NUM_SLOTS_DEF,
  parameter int KEY_WIDTH = qph_pkg::KEY_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  qph_req_if.sink    req,
  qph_rsp_if.source  rsp
);
  import qph_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  qph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table storage and arithmetic
  qph_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (req.req_type),
    .in_key      (req.key),
    .out_success (rsp.success),
    .out_slot    (rsp.slot)
  );

endmodule
`default_nettype wire
